// ----- hdl/ols_pkg.sv -----
// Package for the ordered list store: sizes, command and state codes,
// and the circular-buffer address helper. Depends on nothing.
package ols_pkg;

   localparam int CAPACITY = 32;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 6;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [IDX_W:0]     idx_ext_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [CMP_W-1:0]   cmp_type;

   typedef enum logic [1:0] {
      CMD_INSERT_FRONT = 2'd0,
      CMD_APPEND       = 2'd1,
      CMD_DELETE       = 2'd2,
      CMD_NOP          = 2'd3
   } cmd_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_DUMP = 1'b1
   } state_type;

   // Map a logical offset from the front to a physical slot. Both inputs
   // stay below CAPACITY, so one conditional subtract wraps the sum.
   function automatic idx_type phys_addr(input idx_type head, input idx_type ofs);
      idx_ext_type sum;
      sum = {1'b0, head} + {1'b0, ofs};
      if (sum >= idx_ext_type'(CAPACITY)) begin
         sum = sum - idx_ext_type'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// ----- hdl/ordered_list_store_unit.sv -----
// Ordered list store: bounded sequence of signed 32-bit values in a circular RAM.
// The first result passes through the dump state, the registered RAM read and the
// output register; for an empty list the marker is loaded straight from the dump state.
// A new request is taken only once the whole list has been sent; the single RAM read
// port, one entry a cycle while rsp_ready does not stall the output, sets the pace.
// Reset (synchronous, active high) empties the list and clears all handshakes;
// RAM contents stay undefined, and only entries below the count are ever read.
module ordered_list_store_unit (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_cmd,
   input  logic signed [31:0]  req_item_value,
   input  logic [5:0]          req_position,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_entry_value,
   output logic                rsp_is_last,
   output logic                rsp_list_empty,
   output logic                rsp_insert_dropped
);

   // ------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------
   ols_pkg::state_type state_ff, state_in;
   ols_pkg::idx_type   head_ff, head_in;      // physical slot of the front entry
   ols_pkg::cnt_type   count_ff, count_in;    // entries held
   ols_pkg::cnt_type   rd_idx_ff, rd_idx_in;  // next logical index to read
   ols_pkg::cnt_type   out_idx_ff, out_idx_in; // next logical index to emit
   logic               rdv_ff, rdv_in;        // RAM read data holds an unsent entry
   logic               del_act_ff, del_act_in; // compact the list during this dump
   ols_pkg::idx_type   del_pos_ff, del_pos_in;
   logic               drop_ff, drop_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]  rsp_entry_value_ff, rsp_entry_value_in;
   logic                rsp_is_last_ff, rsp_is_last_in;
   logic                rsp_list_empty_ff, rsp_list_empty_in;
   logic                rsp_insert_dropped_ff, rsp_insert_dropped_in;

   // RAM ports
   logic                ram_wr_en;
   ols_pkg::idx_type    ram_wr_addr;
   ols_pkg::value_type  ram_wr_data;
   logic                ram_rd_en;
   ols_pkg::idx_type    ram_rd_addr;
   ols_pkg::value_type  ram_rd_data;

   // helpers
   logic                req_fire;
   logic                out_free;
   logic                load_ram;
   logic                issue;
   logic                shift;
   logic                full;
   logic                pos_ok;
   ols_pkg::idx_type    head_dec;
   ols_pkg::cnt_type    src_idx;

   ols_ram #(
      .WIDTH (ols_pkg::VALUE_W),
      .DEPTH (ols_pkg::CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------
   // Handshake helpers
   // ------------------------------------------------------------------
   assign req_ready = (state_ff == ols_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign full     = (count_ff == ols_pkg::cnt_type'(ols_pkg::CAPACITY));
   assign pos_ok   = (ols_pkg::cmp_type'(req_position) < ols_pkg::cmp_type'(count_ff));
   assign head_dec = (head_ff == '0) ? ols_pkg::idx_type'(ols_pkg::CAPACITY - 1)
                                     : head_ff - ols_pkg::idx_type'(1);

   // Skip the deleted slot: logical entry i of the new list sits at i+1
   // of the old one once i reaches the delete position.
   assign shift   = del_act_ff && (rd_idx_ff >= ols_pkg::cnt_type'(del_pos_ff));
   assign src_idx = rd_idx_ff + ols_pkg::cnt_type'(shift);

   // Move RAM data to the output register whenever it frees up, and keep
   // one read in flight behind it.
   assign load_ram = (state_ff == ols_pkg::ST_DUMP) && rdv_ff && out_free;
   assign issue    = (state_ff == ols_pkg::ST_DUMP) && (rd_idx_ff < count_ff) &&
                     (!rdv_ff || load_ram);

   assign ram_rd_en   = issue;
   assign ram_rd_addr = ols_pkg::phys_addr(head_ff, ols_pkg::idx_type'(src_idx));

   // ------------------------------------------------------------------
   // Next state and outputs
   // ------------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      rd_idx_in  = rd_idx_ff;
      out_idx_in = out_idx_ff;
      rdv_in     = rdv_ff;
      del_act_in = del_act_ff;
      del_pos_in = del_pos_ff;
      drop_in    = drop_ff;

      rsp_valid_in          = rsp_valid_ff && !rsp_ready;
      rsp_entry_value_in    = rsp_entry_value_ff;
      rsp_is_last_in        = rsp_is_last_ff;
      rsp_list_empty_in     = rsp_list_empty_ff;
      rsp_insert_dropped_in = rsp_insert_dropped_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = head_ff;
      ram_wr_data = req_item_value;

      case (state_ff)
         ols_pkg::ST_IDLE: begin
            if (req_fire) begin
               // Apply inserts right away; deletes are folded into the dump.
               rd_idx_in  = '0;
               out_idx_in = '0;
               rdv_in     = 1'b0;
               del_act_in = 1'b0;
               del_pos_in = ols_pkg::idx_type'(req_position);
               drop_in    = 1'b0;
               state_in   = ols_pkg::ST_DUMP;
               case (ols_pkg::cmd_type'(req_cmd))
                  ols_pkg::CMD_INSERT_FRONT: begin
                     if (full) begin
                        drop_in = 1'b1;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = head_dec;
                        head_in     = head_dec;
                        count_in    = count_ff + ols_pkg::cnt_type'(1);
                     end
                  end
                  ols_pkg::CMD_APPEND: begin
                     if (full) begin
                        drop_in = 1'b1;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = ols_pkg::phys_addr(head_ff,
                                         ols_pkg::idx_type'(count_ff));
                        count_in    = count_ff + ols_pkg::cnt_type'(1);
                     end
                  end
                  ols_pkg::CMD_DELETE: begin
                     if (pos_ok) begin
                        del_act_in = 1'b1;
                        count_in   = count_ff - ols_pkg::cnt_type'(1);
                     end
                  end
                  default: begin
                     // no change: dump as is
                  end
               endcase
            end
         end

         ols_pkg::ST_DUMP: begin
            if (count_ff == '0) begin
               // Empty list: one marker item.
               if (out_free) begin
                  rsp_valid_in          = 1'b1;
                  rsp_entry_value_in    = '0;
                  rsp_is_last_in        = 1'b1;
                  rsp_list_empty_in     = 1'b1;
                  rsp_insert_dropped_in = drop_ff;
                  state_in              = ols_pkg::ST_IDLE;
               end
            end else begin
               if (issue) begin
                  rd_idx_in = rd_idx_ff + ols_pkg::cnt_type'(1);
               end
               if (issue) begin
                  rdv_in = 1'b1;
               end else if (load_ram) begin
                  rdv_in = 1'b0;
               end
               if (load_ram) begin
                  rsp_valid_in          = 1'b1;
                  rsp_entry_value_in    = $signed(ram_rd_data);
                  rsp_is_last_in        = (out_idx_ff + ols_pkg::cnt_type'(1) == count_ff);
                  rsp_list_empty_in     = 1'b0;
                  rsp_insert_dropped_in = drop_ff;
                  out_idx_in            = out_idx_ff + ols_pkg::cnt_type'(1);
                  // Write the shifted entry back into its new slot.
                  if (del_act_ff && (out_idx_ff >= ols_pkg::cnt_type'(del_pos_ff))) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = ols_pkg::phys_addr(head_ff,
                                      ols_pkg::idx_type'(out_idx_ff));
                     ram_wr_data = ram_rd_data;
                  end
                  if (out_idx_ff + ols_pkg::cnt_type'(1) == count_ff) begin
                     state_in = ols_pkg::ST_IDLE;
                  end
               end
            end
         end

         default: begin
            state_in = ols_pkg::ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ols_pkg::ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         out_idx_ff   <= '0;
         rdv_ff       <= 1'b0;
         del_act_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         out_idx_ff   <= out_idx_in;
         rdv_ff       <= rdv_in;
         del_act_ff   <= del_act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      del_pos_ff            <= del_pos_in;
      drop_ff               <= drop_in;
      rsp_entry_value_ff    <= rsp_entry_value_in;
      rsp_is_last_ff        <= rsp_is_last_in;
      rsp_list_empty_ff     <= rsp_list_empty_in;
      rsp_insert_dropped_ff <= rsp_insert_dropped_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_entry_value    = rsp_entry_value_ff;
   assign rsp_is_last        = rsp_is_last_ff;
   assign rsp_list_empty     = rsp_list_empty_ff;
   assign rsp_insert_dropped = rsp_insert_dropped_ff;

endmodule

// ----- hdl/ols_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued. No dependencies.
module ols_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
